// ===== sv/hhpd_pkg.sv =====
// Shared constants, codes and state type of the hold-at-centre PD force controller.
`default_nettype none
package hhpd_pkg;

  localparam int VALUE_WIDTH_DEF = 32;

  localparam int ONE_Q        = 65536;
  localparam int HOLD_ROT_G   = 104858;
  localparam int HOLD_GAP     = 33423;
  localparam int GRIP_KP      = 6553600;
  localparam int GRIP_KV      = 327680;
  localparam int GRIP_MAX     = 65536;
  localparam int TORQUE_GUARD = 6553600;

  localparam logic [23:0] KP_RESET     = 24'd6553600;
  localparam logic [23:0] KV_RESET     = 24'd1310720;
  localparam logic [23:0] MF_RESET     = 24'd131072;
  localparam logic [23:0] KR_RESET     = 24'd655;
  localparam logic [23:0] KW_RESET     = 24'd2621;
  localparam logic [23:0] MT_RESET     = 24'd1311;
  localparam logic [16:0] FC_RESET     = 17'd1966;
  localparam logic [23:0] FG_RESET     = 24'd655360;

  localparam logic [1:0] OP_WRENCH = 2'd0;
  localparam logic [1:0] OP_LINEAR = 2'd1;
  localparam logic [1:0] OP_WRIST  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  typedef enum logic [2:0] {
    CFG_KP, CFG_KV, CFG_MAX_FORCE, CFG_KR, CFG_KW, CFG_MAX_TORQUE, CFG_FILTER, CFG_GUARD
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_TQ_A, S_TQ_B, S_TQ_C, S_GF_A, S_GF_B, S_FN_A, S_FN_B, S_FN_C,
    S_GR_A, S_GR_B, S_GR_C, S_SHIFT, S_SQ_A, S_SQ_B, S_RT_GO, S_RT_WAIT, S_CMP,
    S_DV_A, S_DV_B, S_DV_WAIT, S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic done;
  } unit_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/hhpd_mul.sv =====
// Shared registered magnitude multiplier with sign tag.
`default_nettype none
module hhpd_mul #(
  parameter int A_WIDTH = 34
) (
  input  wire logic                 clk,
  input  wire logic [A_WIDTH-1:0]   a,
  input  wire logic [31:0]          b,
  input  wire logic                 neg,
  output logic      [A_WIDTH+31:0]  prod,
  output logic                      prod_neg
);
  always_ff @(posedge clk) begin
    prod     <= (A_WIDTH+32)'(a) * (A_WIDTH+32)'(b);
    prod_neg <= neg;
  end
endmodule
`default_nettype wire

// ===== sv/hhpd_isqrt.sv =====
// Iterative 64-bit integer square root, one result bit per cycle.
`default_nettype none
module hhpd_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic             done,
  output logic [31:0]      root
);
  logic [63:0] n, r, b;
  logic [4:0]  cnt;
  logic        busy;
  logic [63:0] trial;

  assign trial = r + b;
  assign root  = r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n <= radicand;
      r <= '0;
      b <= 64'd1 << 62;
    end else if (busy) begin
      if (n >= trial) begin
        n <= n - trial;
        r <= (r >> 1) + b;
      end else begin
        r <= r >> 1;
      end
      b <= b >> 2;
    end
  end
endmodule
`default_nettype wire

// ===== sv/hhpd_div.sv =====
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
`default_nettype none
module hhpd_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);
  logic [63:0] num;
  logic [63:0] q;
  logic [31:0] den;
  logic [32:0] rem, rem_sh;
  logic [5:0]  cnt;
  logic        busy;
  logic        fits;

  assign rem_sh   = {rem[31:0], num[63]};
  assign fits     = rem_sh >= {1'b0, den};
  assign quotient = q[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      den <= divisor;
      rem <= '0;
      q   <= '0;
    end else if (busy) begin
      num <= num << 1;
      rem <= fits ? rem_sh - {1'b0, den} : rem_sh;
      q   <= {q[62:0], fits};
    end
  end
endmodule
`default_nettype wire

// ===== sv/haptic_hold_pd_force_controller_top.sv =====
// Top level of the hold-at-centre PD force controller with force magnitude limit.
`default_nettype none
// Op 0 (wrench) and op 1 (linear sample) are stored in the cycle of their transfer and give no
// result; op 3 is dropped. Op 2 starts a computation on one shared registered multiplier under
// a small sequencer: first the wrist torques, then either the guarded low-pass or, in normal
// mode, the PD force, the gripper, the range shift, the squares and the square root (32 steps).
// When the force exceeds its limit and must be scaled, each axis adds a 64-step division. The
// input is stalled from the op 2 transfer until the result is loaded into the output register;
// the result then waits there for its transfer while the next input is taken. Configuration
// writes take effect at once.
module haptic_hold_pd_force_controller_top #(
  parameter int VALUE_WIDTH = hhpd_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         op,
  input  wire logic signed [31:0] x_value,
  input  wire logic signed [31:0] y_value,
  input  wire logic signed [31:0] z_value,
  input  wire logic signed [31:0] x_rate,
  input  wire logic signed [31:0] y_rate,
  input  wire logic signed [31:0] z_rate,
  input  wire logic signed [31:0] aux_value,
  input  wire logic signed [31:0] aux_rate,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      force_x,
  output logic signed [31:0]      force_y,
  output logic signed [31:0]      force_z,
  output logic signed [31:0]      torque_a,
  output logic signed [31:0]      torque_b,
  output logic signed [31:0]      torque_g,
  output logic signed [31:0]      grip_force,
  output logic                    guarded,
  input  wire logic               cfg_write_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [23:0]        cfg_data
);
  // FW holds a force, wide enough for a scaled force; MW holds a multiplier magnitude.
  localparam int FW = (VALUE_WIDTH > 26) ? VALUE_WIDTH : 26;
  localparam int MW = (VALUE_WIDTH + 2 > 34) ? VALUE_WIDTH + 2 : 34;
  localparam int PW = MW + 32;
  localparam int XW = PW - 14;
  localparam int KW = $clog2(VALUE_WIDTH);
  localparam logic signed [XW:0] SAT_HI = {{(XW + 2 - VALUE_WIDTH){1'b0}},
                                           {(VALUE_WIDTH - 1){1'b1}}};
  localparam logic signed [XW:0] SAT_LO = ~SAT_HI;

  // configuration
  logic [23:0] kp_gain, kv_gain, max_force, kr_gain, kw_gain, max_torque, force_guard;
  logic [16:0] filter_coeff;

  // held state
  logic signed [31:0]    held_position [3];
  logic signed [31:0]    held_velocity [3];
  logic signed [31:0]    held_gap, held_gap_rate;
  logic signed [31:0]    ext_force [3];
  logic signed [31:0]    ext_torque [3];
  logic signed [FW-1:0]  last_force [3];

  // per-item working registers
  logic signed [31:0]    angle [3];
  logic signed [31:0]    wrate [3];
  logic signed [FW-1:0]  fv [3];
  logic signed [31:0]    tq [3];
  logic signed [31:0]    grip;
  logic                  guard_r;
  logic signed [XW-1:0]  acc;
  logic [1:0]            idx;
  logic [KW-1:0]         k;
  logic [63:0]           sum;

  hhpd_pkg::state_t state, state_next;

  // shared multiplier
  logic [MW-1:0] mul_a;
  logic [31:0]   mul_b;
  logic          mul_neg;
  logic [PW-1:0] prod;
  logic          prod_neg;
  logic [PW:0]   rnd_sum;
  logic [PW-16:0] rmag;
  logic signed [XW-1:0] mulr;

  hhpd_pkg::unit_ctrl_t sq_ctrl, dv_ctrl;
  logic [31:0] root, quot;

  function automatic logic [MW-1:0] mag_of(input logic signed [MW:0] v);
    logic [MW:0] t;
    t = (v < 0) ? -v : v;
    return t[MW-1:0];
  endfunction

  hhpd_mul #(.A_WIDTH(MW)) u_mul (
    .clk(clk), .a(mul_a), .b(mul_b), .neg(mul_neg), .prod(prod), .prod_neg(prod_neg)
  );

  // round half away from zero back to Q16.16
  assign rnd_sum = {1'b0, prod} + (PW+1)'(32768);
  assign rmag    = rnd_sum[PW:16];
  assign mulr    = prod_neg ? -signed'({1'b0, rmag}) : signed'({1'b0, rmag});

  // guard test on the stored wrench
  logic guard_hit;
  always_comb begin
    logic signed [32:0] e;
    logic [32:0] em;
    guard_hit = 1'b0;
    for (int i = 0; i < 3; i++) begin
      e  = 33'(ext_force[i]);
      em = (e < 0) ? -e : e;
      if (em >= 33'(force_guard)) guard_hit = 1'b1;
      e  = 33'(ext_torque[i]);
      em = (e < 0) ? -e : e;
      if (em >= 33'(hhpd_pkg::TORQUE_GUARD)) guard_hit = 1'b1;
    end
  end

  // low-pass targets: quarter of the external force, x negated
  logic signed [33:0] target [3];
  always_comb begin
    logic signed [33:0] e;
    logic [33:0] em, qm;
    for (int i = 0; i < 3; i++) begin
      e  = 34'(ext_force[i]);
      em = (e < 0) ? -e : e;
      qm = (em + 34'd2) >> 2;
      target[i] = (e < 0) ? -signed'(qm) : signed'(qm);
      if (i == 0) target[i] = -target[i];
    end
  end

  // magnitudes for the limit test
  logic [FW-1:0] fmag [3];
  logic [FW-1:0] maxm;
  always_comb begin
    maxm = '0;
    for (int i = 0; i < 3; i++) begin
      fmag[i] = (fv[i] < 0) ? FW'(-fv[i]) : FW'(fv[i]);
      if (fmag[i] > maxm) maxm = fmag[i];
    end
  end

  logic [63:0] maxm_sh, s_sh, root_sh;
  logic [31:0] s_sel;
  logic        shift_more;
  assign maxm_sh    = 64'(maxm) >> k;
  assign shift_more = maxm_sh >= 64'h8000_0000;
  assign s_sh       = 64'(fmag[idx]) >> k;
  assign s_sel      = s_sh[31:0];
  assign root_sh    = 64'(root) << k;

  logic [16:0] coef;
  assign coef = (filter_coeff > 17'(hhpd_pkg::ONE_Q)) ? 17'(hhpd_pkg::ONE_Q) : filter_coeff;

  // combine and clamp
  logic signed [XW:0] dsum, gsum, tlim, glim, tcl, gcl, fsat_d, fsat_g;
  assign dsum = (XW+1)'(acc) - (XW+1)'(mulr);
  assign gsum = (XW+1)'(last_force[idx]) + (XW+1)'(mulr);
  assign tlim = signed'({{(XW - 23){1'b0}}, max_torque});
  assign glim = (XW+1)'(hhpd_pkg::GRIP_MAX);
  assign tcl  = (dsum > tlim) ? tlim : ((dsum < -tlim) ? -tlim : dsum);
  assign gcl  = (dsum > glim) ? glim : ((dsum < -glim) ? -glim : dsum);
  assign fsat_d = (dsum > SAT_HI) ? SAT_HI : ((dsum < SAT_LO) ? SAT_LO : dsum);
  assign fsat_g = (gsum > SAT_HI) ? SAT_HI : ((gsum < SAT_LO) ? SAT_LO : gsum);

  logic signed [FW-1:0] qs;
  assign qs = signed'(FW'(quot));

  logic in_xfer, out_free;
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  hhpd_isqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_ctrl.start), .radicand(sum),
    .done(sq_ctrl.done), .root(root)
  );

  hhpd_div u_div (
    .clk(clk), .rst(rst), .start(dv_ctrl.start),
    .dividend(prod[63:0] + 64'(root >> 1)), .divisor(root),
    .done(dv_ctrl.done), .quotient(quot)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= hhpd_pkg::S_IDLE;
    else     state <= state_next;
  end

  // next state, multiplier operands and unit starts
  always_comb begin
    logic signed [MW:0] opnd;
    state_next    = state;
    in_stall      = 1'b1;
    mul_a         = '0;
    mul_b         = '0;
    mul_neg       = 1'b0;
    sq_ctrl.start = 1'b0;
    dv_ctrl.start = 1'b0;
    opnd          = '0;
    unique case (state)
      hhpd_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && op == hhpd_pkg::OP_WRIST) state_next = hhpd_pkg::S_TQ_A;
      end
      hhpd_pkg::S_TQ_A: begin
        opnd = (MW+1)'(((idx == 2'd2) ? 34'(hhpd_pkg::HOLD_ROT_G) : 34'sd0)
                       - 34'(angle[idx]));
        mul_a = mag_of(opnd); mul_neg = opnd < 0; mul_b = 32'(kr_gain);
        state_next = hhpd_pkg::S_TQ_B;
      end
      hhpd_pkg::S_TQ_B: begin
        opnd = (MW+1)'(wrate[idx]);
        mul_a = mag_of(opnd); mul_neg = opnd < 0; mul_b = 32'(kw_gain);
        state_next = hhpd_pkg::S_TQ_C;
      end
      hhpd_pkg::S_TQ_C: begin
        if (idx != 2'd2)  state_next = hhpd_pkg::S_TQ_A;
        else if (guard_r) state_next = hhpd_pkg::S_GF_A;
        else              state_next = hhpd_pkg::S_FN_A;
      end
      hhpd_pkg::S_GF_A: begin
        opnd = (MW+1)'(target[idx]) - (MW+1)'(last_force[idx]);
        mul_a = mag_of(opnd); mul_neg = opnd < 0; mul_b = 32'(coef);
        state_next = hhpd_pkg::S_GF_B;
      end
      hhpd_pkg::S_GF_B: begin
        state_next = (idx == 2'd2) ? hhpd_pkg::S_DONE : hhpd_pkg::S_GF_A;
      end
      hhpd_pkg::S_FN_A: begin
        opnd = (MW+1)'(held_position[idx]);
        mul_a = mag_of(opnd); mul_neg = opnd > 0; mul_b = 32'(kp_gain);
        state_next = hhpd_pkg::S_FN_B;
      end
      hhpd_pkg::S_FN_B: begin
        opnd = (MW+1)'(held_velocity[idx]);
        mul_a = mag_of(opnd); mul_neg = opnd < 0; mul_b = 32'(kv_gain);
        state_next = hhpd_pkg::S_FN_C;
      end
      hhpd_pkg::S_FN_C: begin
        state_next = (idx == 2'd2) ? hhpd_pkg::S_GR_A : hhpd_pkg::S_FN_A;
      end
      hhpd_pkg::S_GR_A: begin
        opnd = (MW+1)'(34'(hhpd_pkg::HOLD_GAP) - 34'(held_gap));
        mul_a = mag_of(opnd); mul_neg = opnd < 0; mul_b = 32'(hhpd_pkg::GRIP_KP);
        state_next = hhpd_pkg::S_GR_B;
      end
      hhpd_pkg::S_GR_B: begin
        opnd = (MW+1)'(held_gap_rate);
        mul_a = mag_of(opnd); mul_neg = opnd < 0; mul_b = 32'(hhpd_pkg::GRIP_KV);
        state_next = hhpd_pkg::S_GR_C;
      end
      hhpd_pkg::S_GR_C: state_next = hhpd_pkg::S_SHIFT;
      hhpd_pkg::S_SHIFT: begin
        if (!shift_more) state_next = hhpd_pkg::S_SQ_A;
      end
      hhpd_pkg::S_SQ_A: begin
        mul_a = MW'(s_sel); mul_b = s_sel;
        state_next = hhpd_pkg::S_SQ_B;
      end
      hhpd_pkg::S_SQ_B: begin
        state_next = (idx == 2'd2) ? hhpd_pkg::S_RT_GO : hhpd_pkg::S_SQ_A;
      end
      hhpd_pkg::S_RT_GO: begin
        sq_ctrl.start = 1'b1;
        state_next = hhpd_pkg::S_RT_WAIT;
      end
      hhpd_pkg::S_RT_WAIT: begin
        if (sq_ctrl.done) state_next = hhpd_pkg::S_CMP;
      end
      hhpd_pkg::S_CMP: begin
        state_next = (root_sh > 64'(max_force)) ? hhpd_pkg::S_DV_A : hhpd_pkg::S_DONE;
      end
      hhpd_pkg::S_DV_A: begin
        mul_a = MW'(s_sel); mul_b = 32'(max_force);
        state_next = hhpd_pkg::S_DV_B;
      end
      hhpd_pkg::S_DV_B: begin
        dv_ctrl.start = 1'b1;
        state_next = hhpd_pkg::S_DV_WAIT;
      end
      hhpd_pkg::S_DV_WAIT: begin
        if (dv_ctrl.done)
          state_next = (idx == 2'd2) ? hhpd_pkg::S_DONE : hhpd_pkg::S_DV_A;
      end
      hhpd_pkg::S_DONE: begin
        if (out_free) state_next = hhpd_pkg::S_IDLE;
      end
      default: state_next = hhpd_pkg::S_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain      <= hhpd_pkg::KP_RESET;
      kv_gain      <= hhpd_pkg::KV_RESET;
      max_force    <= hhpd_pkg::MF_RESET;
      kr_gain      <= hhpd_pkg::KR_RESET;
      kw_gain      <= hhpd_pkg::KW_RESET;
      max_torque   <= hhpd_pkg::MT_RESET;
      filter_coeff <= hhpd_pkg::FC_RESET;
      force_guard  <= hhpd_pkg::FG_RESET;
    end else if (cfg_write_en) begin
      unique case (hhpd_pkg::cfg_idx_t'(cfg_index))
        hhpd_pkg::CFG_KP:         kp_gain      <= cfg_data;
        hhpd_pkg::CFG_KV:         kv_gain      <= cfg_data;
        hhpd_pkg::CFG_MAX_FORCE:  max_force    <= cfg_data;
        hhpd_pkg::CFG_KR:         kr_gain      <= cfg_data;
        hhpd_pkg::CFG_KW:         kw_gain      <= cfg_data;
        hhpd_pkg::CFG_MAX_TORQUE: max_torque   <= cfg_data;
        hhpd_pkg::CFG_FILTER:     filter_coeff <= cfg_data[16:0];
        hhpd_pkg::CFG_GUARD:      force_guard  <= cfg_data;
        default: ;
      endcase
    end
  end

  // held state: store the wrench and linear sample, advance the low-pass memory on a result
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        held_position[i] <= '0;
        held_velocity[i] <= '0;
        ext_force[i]     <= '0;
        ext_torque[i]    <= '0;
        last_force[i]    <= '0;
      end
      held_gap      <= 32'(hhpd_pkg::HOLD_GAP);
      held_gap_rate <= '0;
    end else begin
      if (in_xfer && op == hhpd_pkg::OP_WRENCH) begin
        ext_force[0] <= x_value; ext_force[1] <= y_value; ext_force[2] <= z_value;
        ext_torque[0] <= x_rate; ext_torque[1] <= y_rate; ext_torque[2] <= z_rate;
      end
      if (in_xfer && op == hhpd_pkg::OP_LINEAR) begin
        held_position[0] <= x_value; held_position[1] <= y_value;
        held_position[2] <= z_value;
        held_velocity[0] <= x_rate; held_velocity[1] <= y_rate;
        held_velocity[2] <= z_rate;
        held_gap      <= aux_value;
        held_gap_rate <= aux_rate;
      end
      if (state == hhpd_pkg::S_DONE && out_free) begin
        for (int i = 0; i < 3; i++) last_force[i] <= fv[i];
      end
    end
  end

  // working registers of one computation
  always_ff @(posedge clk) begin
    case (state)
      hhpd_pkg::S_IDLE: begin
        idx <= 2'd0;
        if (in_xfer && op == hhpd_pkg::OP_WRIST) begin
          angle[0] <= x_value; angle[1] <= y_value; angle[2] <= z_value;
          wrate[0] <= x_rate;  wrate[1] <= y_rate;  wrate[2] <= z_rate;
          guard_r  <= guard_hit;
        end
      end
      hhpd_pkg::S_TQ_B, hhpd_pkg::S_FN_B, hhpd_pkg::S_GR_B: acc <= mulr;
      hhpd_pkg::S_TQ_C: begin
        tq[idx] <= tcl[31:0];
        idx     <= (idx == 2'd2) ? 2'd0 : idx + 2'd1;
        grip    <= '0;
      end
      hhpd_pkg::S_GF_B: begin
        fv[idx] <= FW'(fsat_g);
        idx     <= idx + 2'd1;
      end
      hhpd_pkg::S_FN_C: begin
        fv[idx] <= FW'(fsat_d);
        idx     <= (idx == 2'd2) ? 2'd0 : idx + 2'd1;
      end
      hhpd_pkg::S_GR_C: begin
        grip <= gcl[31:0];
        k    <= '0;
        sum  <= '0;
      end
      hhpd_pkg::S_SHIFT: begin
        if (shift_more) k <= k + KW'(1);
      end
      hhpd_pkg::S_SQ_B: begin
        sum <= sum + prod[63:0];
        idx <= (idx == 2'd2) ? 2'd0 : idx + 2'd1;
      end
      hhpd_pkg::S_DV_WAIT: begin
        if (dv_ctrl.done) begin
          fv[idx] <= (fv[idx] < 0) ? -qs : qs;
          idx     <= idx + 2'd1;
        end
      end
      default: ;
    endcase
  end

  // output register: load on the way out of DONE, hold until the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == hhpd_pkg::S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  logic signed [63:0] f64 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) f64[i] = 64'(fv[i]);
  end

  always_ff @(posedge clk) begin
    if (state == hhpd_pkg::S_DONE && out_free) begin
      force_x    <= f64[0][31:0];
      force_y    <= f64[1][31:0];
      force_z    <= f64[2][31:0];
      torque_a   <= tq[0];
      torque_b   <= tq[1];
      torque_g   <= tq[2];
      grip_force <= grip;
      guarded    <= guard_r;
    end
  end
endmodule
`default_nettype wire

// ===== sv/hhpd_checker.sv =====
// Port-level checks of the hold-at-centre PD force controller, bound to its top level.
`default_nettype none
module hhpd_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic [1:0]        op,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic signed [31:0] force_x,
  input wire logic signed [31:0] grip_force,
  input wire logic              guarded
);
  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(force_x) && $stable(grip_force))
    else $error("stalled result changed");

  // a compute transfer makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op == hhpd_pkg::OP_WRIST |=> in_stall)
    else $error("compute transfer did not make the block busy");

  // no gripper force while guarded
  a_guard_grip: assert property (@(posedge clk) disable iff (rst)
    out_valid && guarded |-> grip_force == 32'sd0)
    else $error("gripper force while guarded");

  // gripper force within its clamp
  a_grip_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (grip_force <= 32'sd65536 && grip_force >= -32'sd65536))
    else $error("gripper force outside clamp");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind haptic_hold_pd_force_controller_top hhpd_checker u_hhpd_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .op(op),
  .out_valid(out_valid), .out_stall(out_stall), .force_x(force_x),
  .grip_force(grip_force), .guarded(guarded)
);
`default_nettype wire
